### design/wlrs_pkg.sv
// ----------------------------------------------------------------------------
// wlrs_pkg
// Shared types and constants of the window level run segmenter.
// ----------------------------------------------------------------------------
package wlrs_pkg;

    localparam int WINDOW_LEN  = 5;
    localparam int TAPS        = WINDOW_LEN - 1;
    localparam int BOUND_W     = 13;   // 5 * (1023 + 1) fits
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_PTR_W = 3;
    localparam int QUEUE_CNT_W = 4;
    localparam int CFG_INDEX_W = 3;

    localparam logic [1:0] LEVEL_LOW  = 2'd0;
    localparam logic [1:0] LEVEL_MID  = 2'd1;
    localparam logic [1:0] LEVEL_HIGH = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_OFFSET   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_STRIDE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_THRESHOLD = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_THRESHOLD  = 3'd3;

    typedef struct packed {
        logic [1:0]  level;
        logic [31:0] start;
        logic [31:0] length;
        logic [31:0] stop_frame;
        logic        last;
    } run_result_t;

    // up to two finished runs handed to the output queue in one cycle
    typedef struct packed {
        logic [1:0]  count;
        run_result_t first;
        run_result_t second;
    } run_push_t;

endpackage

### design/wlrs_sample_cell.sv
// ----------------------------------------------------------------------------
// wlrs_sample_cell
// One tap of the sample delay line: holds a sample, takes its neighbor's.
// ----------------------------------------------------------------------------
module wlrs_sample_cell #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   shift,
    input  logic                   clear,
    input  logic [SAMPLE_BITS-1:0] d,
    output logic [SAMPLE_BITS-1:0] q
);

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] sample_next;

    always_comb
    begin
        sample_next = sample_reg;
        if (clear)
        begin
            sample_next = '0;
        end
        else if (shift)
        begin
            sample_next = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
        end
    end

    assign q = sample_reg;

endmodule

### design/wlrs_run_tracker.sv
// ----------------------------------------------------------------------------
// wlrs_run_tracker
// Classifies a window sum and merges equal-level windows into runs.
// ----------------------------------------------------------------------------
module wlrs_run_tracker #(
    parameter int SUM_W = 13
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               win_valid,
    input  logic               win_eval,
    input  logic               win_final,
    input  logic [SUM_W-1:0]   win_sum,
    input  logic [31:0]        win_frame,
    input  logic [7:0]         win_stride,
    input  logic [9:0]         high_thr,
    input  logic [9:0]         low_thr,
    output wlrs_pkg::run_push_t push
);

    localparam int CMP_W = (SUM_W > wlrs_pkg::BOUND_W) ? SUM_W : wlrs_pkg::BOUND_W;

    logic        open_reg,   open_next;
    logic [1:0]  level_reg,  level_next;
    logic [31:0] start_reg,  start_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] lastw_reg,  lastw_next;

    logic [wlrs_pkg::BOUND_W-1:0] hi_bound;
    logic [wlrs_pkg::BOUND_W-1:0] lo_bound;
    logic [CMP_W-1:0]             sum_ext;
    logic [1:0]                   lvl;
    logic                         same;
    logic                         closed;
    logic                         flush;
    logic [32:0]                  len_add;
    wlrs_pkg::run_result_t        old_run;
    wlrs_pkg::run_result_t        new_run;

    // floor(sum / 5) > t  <=>  sum >= 5 * (t + 1)
    assign hi_bound = wlrs_pkg::BOUND_W'({high_thr, 2'b00}) + wlrs_pkg::BOUND_W'(high_thr)
                    + wlrs_pkg::BOUND_W'(5);
    assign lo_bound = wlrs_pkg::BOUND_W'({low_thr, 2'b00}) + wlrs_pkg::BOUND_W'(low_thr)
                    + wlrs_pkg::BOUND_W'(5);
    assign sum_ext  = CMP_W'(win_sum);

    always_comb
    begin
        if (sum_ext >= CMP_W'(hi_bound))
        begin
            lvl = wlrs_pkg::LEVEL_HIGH;
        end
        else if (sum_ext >= CMP_W'(lo_bound))
        begin
            lvl = wlrs_pkg::LEVEL_MID;
        end
        else
        begin
            lvl = wlrs_pkg::LEVEL_LOW;
        end
    end

    assign same    = open_reg && (lvl == level_reg);
    assign len_add = {1'b0, length_reg} + {25'd0, win_stride};
    assign closed  = win_valid && win_eval && open_reg && !same;

    always_comb
    begin
        open_next   = open_reg;
        level_next  = level_reg;
        start_next  = start_reg;
        length_next = length_reg;
        lastw_next  = lastw_reg;
        if (win_valid && win_eval)
        begin
            if (same)
            begin
                length_next = len_add[32] ? '1 : len_add[31:0];
                lastw_next  = win_frame;
            end
            else
            begin
                open_next   = 1'b1;
                level_next  = lvl;
                start_next  = win_frame;
                length_next = {24'd0, win_stride};
                lastw_next  = win_frame;
            end
        end
    end

    assign flush = win_valid && win_final && open_next;

    always_comb
    begin
        old_run.level      = level_reg;
        old_run.start      = start_reg;
        old_run.length     = length_reg;
        old_run.stop_frame = lastw_reg;
        old_run.last       = !flush;
        new_run.level      = level_next;
        new_run.start      = start_next;
        new_run.length     = length_next;
        new_run.stop_frame = lastw_next;
        new_run.last       = 1'b1;

        push.count  = {1'b0, closed} + {1'b0, flush};
        push.first  = closed ? old_run : new_run;
        push.second = new_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= 1'b0;
            level_reg  <= wlrs_pkg::LEVEL_LOW;
            start_reg  <= '0;
            length_reg <= '0;
            lastw_reg  <= '0;
        end
        else if (win_valid && win_final)
        begin
            open_reg   <= 1'b0;
            level_reg  <= wlrs_pkg::LEVEL_LOW;
            start_reg  <= '0;
            length_reg <= '0;
            lastw_reg  <= '0;
        end
        else
        begin
            open_reg   <= open_next;
            level_reg  <= level_next;
            start_reg  <= start_next;
            length_reg <= length_next;
            lastw_reg  <= lastw_next;
        end
    end

    // two results only when a level change meets the end of the series
    a_two_needs_final: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (win_valid && win_final && win_eval))
        else $error("two results without final sample");

    a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (win_valid && win_final) |=> !open_reg)
        else $error("run still open after final sample");

endmodule

### design/wlrs_out_queue.sv
// ----------------------------------------------------------------------------
// wlrs_out_queue
// Result queue: takes up to two runs per cycle, hands out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module wlrs_out_queue (
    input  logic                              clk,
    input  logic                              rst_n,
    input  wlrs_pkg::run_push_t               push,
    input  logic                              out_ready,
    output logic                              out_valid,
    output wlrs_pkg::run_result_t             head,
    output logic [wlrs_pkg::QUEUE_CNT_W-1:0]  level
);

    localparam int PW = wlrs_pkg::QUEUE_PTR_W;
    localparam int CW = wlrs_pkg::QUEUE_CNT_W;

    wlrs_pkg::run_result_t mem [wlrs_pkg::QUEUE_DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [PW-1:0] wr_ptr_plus;
    logic [PW-1:0] tail_ptr;
    logic          pop;

    assign out_valid   = (count_reg != '0);
    assign pop         = out_valid && out_ready;
    assign head        = mem[rd_ptr_reg];
    assign level       = count_reg;
    assign wr_ptr_plus = wr_ptr_reg + PW'(1);
    assign tail_ptr    = wr_ptr_reg - PW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push.count);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_plus] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} + {3'd0, push.count}) <= (CW+1)'(wlrs_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(wlrs_pkg::QUEUE_DEPTH))
        else $error("result queue count out of range");

    // every item's results end with a marked entry, so the newest entry is marked
    a_tail_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> mem[tail_ptr].last)
        else $error("newest queued result not marked last");

endmodule

### design/window_level_run_segmenter_unit.sv
// ----------------------------------------------------------------------------
// window_level_run_segmenter_unit
// Moving five-sample average, three-level classification, run segmentation.
// ----------------------------------------------------------------------------
// One sample is taken per clock cycle while in_ready is high. A sample passes
// a two-stage pipeline: the first stage shifts the four-cell sample line and
// forms the window sum, the second classifies it and updates the open run.
// Finished runs wait in an eight-entry result queue that hands out one run per
// cycle while out_ready is high; input is taken while the queue, counting what
// the pipeline may still add, keeps room for two more runs. A final sample
// that also closes a run yields two runs. Configuration writes are taken in
// any cycle (ready stays high).
module window_level_run_segmenter_unit #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wlrs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [SAMPLE_BITS-1:0]             size_sample,
    input  logic                               final_sample,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         run_level,
    output logic [31:0]                        run_start,
    output logic [31:0]                        run_length,
    output logic [31:0]                        run_end,
    output logic                               last_of_run
);

    localparam int SUM_W = SAMPLE_BITS + 3;
    localparam int TAPS  = wlrs_pkg::TAPS;
    localparam int CW    = wlrs_pkg::QUEUE_CNT_W;

    logic [31:0] offset_reg;
    logic [7:0]  stride_reg;
    logic [9:0]  high_reg;
    logic [9:0]  low_reg;

    logic [31:0] count_reg, count_next;
    logic [7:0]  phase_reg, phase_next;

    logic                    s1_valid_reg;
    logic                    s1_eval_reg,   s1_eval_next;
    logic                    s1_final_reg;
    logic [SUM_W-1:0]        s1_sum_reg,    s1_sum_next;
    logic [31:0]             s1_frame_reg,  s1_frame_next;
    logic [7:0]              s1_stride_reg;

    logic                    accept;
    logic [7:0]              stride_eff;
    logic                    window_full;
    logic [8:0]              phase_inc;
    logic [SAMPLE_BITS-1:0]  tap [TAPS+1];
    logic [CW:0]             committed;

    wlrs_pkg::run_push_t     push;
    wlrs_pkg::run_result_t   head;
    logic [CW-1:0]           q_level;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= 32'd0;
            stride_reg <= 8'd1;
            high_reg   <= 10'd12;
            low_reg    <= 10'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                wlrs_pkg::REG_FRAME_OFFSET:   offset_reg <= cfg_data;
                wlrs_pkg::REG_SAMPLE_STRIDE:  stride_reg <= cfg_data[7:0];
                wlrs_pkg::REG_HIGH_THRESHOLD: high_reg   <= cfg_data[9:0];
                wlrs_pkg::REG_LOW_THRESHOLD:  low_reg    <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // ---------------- input stage ----------------
    assign committed = {1'b0, q_level} + (s1_valid_reg ? (CW+1)'(2) : (CW+1)'(0));
    assign in_ready  = committed <= (CW+1)'(wlrs_pkg::QUEUE_DEPTH - 2);
    assign accept    = in_valid && in_ready;

    assign stride_eff  = (stride_reg == 8'd0) ? 8'd1 : stride_reg;
    assign window_full = count_reg >= 32'(TAPS);
    assign phase_inc   = {1'b0, phase_reg} + 9'd1;

    // tap[0] is the incoming sample, tap[i] the cell i positions back
    assign tap[0] = size_sample;

    for (genvar i = 0; i < TAPS; i++)
    begin : g_cells
        wlrs_sample_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (accept),
            .clear (accept && final_sample),
            .d     (tap[i]),
            .q     (tap[i+1])
        );
    end

    always_comb
    begin
        s1_sum_next = '0;
        for (int i = 0; i <= TAPS; i++)
        begin
            s1_sum_next = s1_sum_next + SUM_W'(tap[i]);
        end
        s1_eval_next  = window_full && (phase_reg == 8'd0);
        s1_frame_next = count_reg - 32'(TAPS) + offset_reg;

        count_next = count_reg + 32'd1;
        phase_next = phase_reg;
        if (window_full)
        begin
            phase_next = (phase_inc >= {1'b0, stride_eff}) ? 8'd0 : phase_inc[7:0];
        end
        if (final_sample)
        begin
            count_next = '0;
            phase_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            phase_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
                phase_reg <= phase_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_eval_reg   <= s1_eval_next;
            s1_final_reg  <= final_sample;
            s1_sum_reg    <= s1_sum_next;
            s1_frame_reg  <= s1_frame_next;
            s1_stride_reg <= stride_eff;
        end
    end

    // ---------------- run stage and queue ----------------
    wlrs_run_tracker #(
        .SUM_W (SUM_W)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .win_valid  (s1_valid_reg),
        .win_eval   (s1_eval_reg),
        .win_final  (s1_final_reg),
        .win_sum    (s1_sum_reg),
        .win_frame  (s1_frame_reg),
        .win_stride (s1_stride_reg),
        .high_thr   (high_reg),
        .low_thr    (low_reg),
        .push       (push)
    );

    wlrs_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .head      (head),
        .level     (q_level)
    );

    assign run_level   = head.level;
    assign run_start   = head.start;
    assign run_length  = head.length;
    assign run_end     = head.stop_frame;
    assign last_of_run = head.last;

endmodule

### verif/tb_window_level_run_segmenter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_window_level_run_segmenter_unit
// Self-checking bench for the window level run segmenter. A driver feeds
// sample requests from a queue with random gaps, a monitor accepts runs with
// random stalls, and a per-sample predictor of the averaging, classification
// and run merging produces the runs each accepted sample must yield. The run
// goes through directed series and random level segments under many register
// settings, including zero and maximum stride, crossed and extreme thresholds.
// ----------------------------------------------------------------------------
module tb_window_level_run_segmenter_unit;

    localparam int SAMPLE_W      = 10;
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int DRAIN_CYCLES  = 8;
    localparam int STALL_LIMIT   = 3000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 75;
    localparam int SHOWN_ERRORS  = 10;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;

    // indexes with no register behind them; writes must leave the setup alone
    localparam logic [wlrs_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd4;
    localparam logic [wlrs_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [SAMPLE_W-1:0] size;
        logic                fin;
    } sample_req_t;

    logic                             clk          = 1'b0;
    logic                             rst_n        = 1'b0;
    logic                             cfg_valid    = 1'b0;
    logic                             cfg_ready;
    logic [wlrs_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [31:0]                      cfg_data     = '0;
    logic                             in_valid     = 1'b0;
    logic                             in_ready;
    logic [SAMPLE_W-1:0]              size_sample  = '0;
    logic                             final_sample = 1'b0;
    logic                             out_valid;
    logic                             out_ready    = 1'b0;
    logic [1:0]                       run_level;
    logic [31:0]                      run_start;
    logic [31:0]                      run_length;
    logic [31:0]                      run_end;
    logic                             last_of_run;

    window_level_run_segmenter_unit #(
        .SAMPLE_BITS (SAMPLE_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .size_sample  (size_sample),
        .final_sample (final_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .run_level    (run_level),
        .run_start    (run_start),
        .run_length   (run_length),
        .run_end      (run_end),
        .last_of_run  (last_of_run)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // register copies
    logic [31:0] offset_reg = '0;
    logic [7:0]  stride_reg = 8'd1;
    logic [9:0]  high_reg   = 10'd12;
    logic [9:0]  low_reg    = 10'd3;

    // series state
    logic [SAMPLE_W-1:0] history [wlrs_pkg::TAPS] = '{default: '0};
    logic [31:0] frames_seen = '0;
    logic [7:0]  slot_phase  = '0;
    logic        run_active  = 1'b0;
    logic [1:0]  open_level  = wlrs_pkg::LEVEL_LOW;
    logic [31:0] open_start  = '0;
    logic [31:0] open_length = '0;
    logic [31:0] open_last   = '0;

    sample_req_t           pending_samples [$];
    wlrs_pkg::run_result_t expected_runs [$];

    int queued_count = 0;
    int taken_count  = 0;
    int runs_checked = 0;
    int error_count  = 0;
    int cfg_writes   = 0;
    int in_gap       = 0;
    int in_calm      = 0;
    int out_stall    = 0;
    int out_calm     = 0;
    int idle_cycles  = 0;

    function automatic wlrs_pkg::run_result_t open_run();
        wlrs_pkg::run_result_t r;
        r.level      = open_level;
        r.start      = open_start;
        r.length     = open_length;
        r.stop_frame = open_last;
        r.last       = 1'b0;
        return r;
    endfunction

    // one sample through window evaluation, run merging and final flush
    task automatic segment_sample(input logic [SAMPLE_W-1:0] s, input logic fin);
        wlrs_pkg::run_result_t fresh [2];
        int          n;
        int          win_sum;
        int          avg;
        logic [1:0]  lvl;
        logic [31:0] f;
        logic [8:0]  stride;
        n = 0;
        stride = (stride_reg == 8'd0) ? 9'd1 : {1'b0, stride_reg};
        if (frames_seen >= wlrs_pkg::TAPS)
        begin
            if (slot_phase == 8'd0)
            begin
                win_sum = s;
                for (int i = 0; i < wlrs_pkg::TAPS; i++)
                    win_sum += history[i];
                avg = win_sum / wlrs_pkg::WINDOW_LEN;
                // high test first, so crossed thresholds still give the top level
                if (avg > high_reg)
                    lvl = wlrs_pkg::LEVEL_HIGH;
                else if (avg > low_reg)
                    lvl = wlrs_pkg::LEVEL_MID;
                else
                    lvl = wlrs_pkg::LEVEL_LOW;
                f = frames_seen - 32'(wlrs_pkg::TAPS) + offset_reg;
                if (run_active && lvl == open_level)
                begin
                    if ({1'b0, open_length} + 33'(stride) > 33'hFFFF_FFFF)
                        open_length = '1;
                    else
                        open_length = open_length + 32'(stride);
                    open_last = f;
                end
                else
                begin
                    if (run_active)
                    begin
                        fresh[n] = open_run();
                        n++;
                    end
                    run_active  = 1'b1;
                    open_level  = lvl;
                    open_start  = f;
                    open_length = 32'(stride);
                    open_last   = f;
                end
            end
            slot_phase = ({1'b0, slot_phase} + 9'd1 >= stride) ? 8'd0 : slot_phase + 8'd1;
        end
        for (int i = wlrs_pkg::TAPS - 1; i > 0; i--)
            history[i] = history[i - 1];
        history[0] = s;
        frames_seen = frames_seen + 32'd1;
        if (fin)
        begin
            if (run_active)
            begin
                fresh[n] = open_run();
                n++;
            end
            history     = '{default: '0};
            frames_seen = '0;
            slot_phase  = '0;
            run_active  = 1'b0;
            open_level  = wlrs_pkg::LEVEL_LOW;
            open_start  = '0;
            open_length = '0;
            open_last   = '0;
        end
        if (n > 0)
            fresh[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_runs.insert(expected_runs.size(), fresh[i]);
    endtask

    // mostly short gaps, some long ones, and now and then a stretch with none
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(99, 0);
        if (r < 3)
        begin
            calm = $urandom_range(100, 20);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic void push_sample(input logic [SAMPLE_W-1:0] s, input logic f);
        sample_req_t req;
        req.size = s;
        req.fin  = f;
        pending_samples.insert(pending_samples.size(), req);
        queued_count++;
    endfunction

    // called in step with the clock; leaves cfg_valid high for a following write
    task automatic write_reg(input logic [wlrs_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            wlrs_pkg::REG_FRAME_OFFSET:   offset_reg = data;
            wlrs_pkg::REG_SAMPLE_STRIDE:  stride_reg = data[7:0];
            wlrs_pkg::REG_HIGH_THRESHOLD: high_reg   = data[9:0];
            wlrs_pkg::REG_LOW_THRESHOLD:  low_reg    = data[9:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic wait_drained();
        while (taken_count != queued_count || expected_runs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // driver: a request leaves the queue when the channel is free and its random gap is over
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                segment_sample(size_sample, final_sample);
                taken_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    sample_req_t req;
                    req = pending_samples.pop_front();
                    size_sample  <= req.size;
                    final_sample <= req.fin;
                    in_valid     <= 1'b1;
                    in_gap = pick_gap(in_calm);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each accepted run against the oldest expected one
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_runs.size() == 0)
                begin
                    error_count++;
                    if (error_count <= SHOWN_ERRORS)
                        $display("unexpected run: lvl=%0d start=%0d len=%0d end=%0d last=%0b",
                                 run_level, run_start, run_length, run_end, last_of_run);
                end
                else
                begin
                    wlrs_pkg::run_result_t want;
                    want = expected_runs.pop_front();
                    runs_checked++;
                    if (run_level !== want.level || run_start !== want.start ||
                        run_length !== want.length || run_end !== want.stop_frame ||
                        last_of_run !== want.last)
                    begin
                        error_count++;
                        if (error_count <= SHOWN_ERRORS)
                            $display({"run %0d mismatch: expected lvl=%0d start=%0d len=%0d ",
                                      "end=%0d last=%0b, got lvl=%0d start=%0d len=%0d ",
                                      "end=%0d last=%0b"},
                                     runs_checked, want.level, want.start, want.length,
                                     want.stop_frame, want.last, run_level, run_start,
                                     run_length, run_end, last_of_run);
                    end
                end
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                out_stall = pick_gap(out_calm);
            end
        end
    end

    // watchdog on cycles without any accepted request
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= STALL_LIMIT)
        begin
            $display("no progress for %0d cycles, %0d runs still expected",
                     STALL_LIMIT, expected_runs.size());
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int         phase_items;
        int         seg_len;
        int         lo;
        int         hi;
        int         pick_low;
        int         pick_high;
        int         pick_stride;
        logic [31:0] pick_offset;
        logic [1:0] band;
        logic [SAMPLE_W-1:0] value;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // final sample on an empty series gives nothing
        push_sample('0, 1'b1);
        // full-scale series, drop to zero, then a final sample that changes level
        repeat (5) push_sample(SAMPLE_W'(SAMPLE_MAX), 1'b0);
        repeat (5) push_sample('0, 1'b0);
        repeat (4) push_sample(SAMPLE_W'(8), 1'b0);
        push_sample(SAMPLE_W'(SAMPLE_MAX), 1'b1);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            pick_offset = $urandom();
            pick_stride = $urandom_range(4, 1);
            pick_low    = $urandom_range(600, 0);
            pick_high   = pick_low + $urandom_range(400, 0);
            if (pick_high > SAMPLE_MAX)
                pick_high = SAMPLE_MAX;
            case (ph)
                0:
                begin
                    // frame numbers wrap soon
                    pick_offset = 32'hFFFF_FFF0;
                    pick_stride = 1;
                    pick_high   = 12;
                    pick_low    = 3;
                end
                1:
                begin
                    pick_stride = 0;
                    pick_high   = SAMPLE_MAX;
                    pick_low    = 0;
                end
                2:
                begin
                    pick_stride = 255;
                    pick_high   = 0;
                    pick_low    = 0;
                end
                3:
                begin
                    pick_high = 100;
                    pick_low  = 900;
                end
                4:
                begin
                    pick_offset = '0;
                    pick_stride = $urandom_range(40, 5);
                end
                default:
                begin
                    if ($urandom_range(9, 0) == 0)
                        pick_low = $urandom_range(SAMPLE_MAX, pick_high);
                    if ($urandom_range(9, 0) == 0)
                        pick_stride = $urandom_range(255, 0);
                end
            endcase
            if (ph == 1)
            begin
                write_reg(REG_SPARE_LO, $urandom());
                write_reg(REG_SPARE_HI, $urandom());
            end
            write_reg(wlrs_pkg::REG_FRAME_OFFSET, pick_offset);
            write_reg(wlrs_pkg::REG_SAMPLE_STRIDE,
                      ($urandom() & 32'hFFFF_FF00) | 32'(pick_stride));
            write_reg(wlrs_pkg::REG_HIGH_THRESHOLD,
                      ($urandom() & 32'hFFFF_FC00) | 32'(pick_high));
            write_reg(wlrs_pkg::REG_LOW_THRESHOLD,
                      ($urandom() & 32'hFFFF_FC00) | 32'(pick_low));
            cfg_valid <= 1'b0;

            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                if ($urandom_range(24, 0) == 0)
                begin
                    // close the series, then one too short to fill a window
                    push_sample(SAMPLE_W'($urandom_range(SAMPLE_MAX, 0)), 1'b1);
                    seg_len = $urandom_range(3, 0);
                    repeat (seg_len) push_sample(SAMPLE_W'($urandom_range(SAMPLE_MAX, 0)), 1'b0);
                    push_sample(SAMPLE_W'($urandom_range(SAMPLE_MAX, 0)), 1'b1);
                    phase_items += seg_len + 2;
                end
                else
                begin
                    // a stretch of samples inside one level band
                    case ($urandom_range(2, 0))
                        0:       band = wlrs_pkg::LEVEL_LOW;
                        1:       band = wlrs_pkg::LEVEL_MID;
                        default: band = wlrs_pkg::LEVEL_HIGH;
                    endcase
                    case (band)
                        wlrs_pkg::LEVEL_HIGH:
                        begin
                            lo = int'(high_reg) + 1;
                            hi = SAMPLE_MAX;
                        end
                        wlrs_pkg::LEVEL_MID:
                        begin
                            lo = int'(low_reg) + 1;
                            hi = int'(high_reg);
                        end
                        default:
                        begin
                            lo = 0;
                            hi = int'(low_reg);
                        end
                    endcase
                    seg_len = $urandom_range(16, 2);
                    repeat (seg_len)
                    begin
                        if (lo > hi || $urandom_range(11, 0) == 0)
                            value = SAMPLE_W'($urandom_range(SAMPLE_MAX, 0));
                        else
                            value = SAMPLE_W'($urandom_range(hi, lo));
                        push_sample(value, $urandom_range(79, 0) == 0);
                    end
                    phase_items += seg_len;
                end
            end
            wait_drained();
        end

        // flush whatever run is still open
        push_sample(SAMPLE_W'($urandom_range(SAMPLE_MAX, 0)), 1'b1);
        wait_drained();

        $display("%0d samples sent, %0d runs checked, %0d register writes over %0d settings",
                 taken_count, runs_checked, cfg_writes, RANDOM_PHASES + 1);
        $display("%0d mismatches, %0d runs left unmatched", error_count, expected_runs.size());
        if (error_count == 0 && expected_runs.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
design/wlrs_pkg.sv
design/wlrs_sample_cell.sv
design/wlrs_run_tracker.sv
design/wlrs_out_queue.sv
design/window_level_run_segmenter_unit.sv
verif/tb_window_level_run_segmenter_unit.sv
